FILE: rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ITP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ITP_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define ITP_ASSERT(lbl, prop, msg)
`define ITP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/core/itp_pkg.sv
// shared types and constants for the interval table point query block
package itp_pkg;

    localparam int DATA_W         = 32;
    localparam int MAX_RANGES_DEF = 64;

    // request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

endpackage

FILE: rtl/core/itp_table.sv
// range table memory: one write port, one registered read port
module itp_table
    import itp_pkg::*;
#(
    parameter int DEPTH = MAX_RANGES_DEF,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_start,
    input  logic signed [DATA_W-1:0] i_wr_end,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_start,
    output logic signed [DATA_W-1:0] o_rd_end
);

    logic [2*DATA_W-1:0] mem [DEPTH];
    logic [2*DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_start, i_wr_end};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_start = $signed(r_rd_data[2*DATA_W-1:DATA_W]);
    assign o_rd_end   = $signed(r_rd_data[DATA_W-1:0]);

endmodule

FILE: rtl/core/itp_scan.sv
// shared compare unit: tracks best start and best end entries over a scan
module itp_scan
    import itp_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_scan_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [AW-1:0]            i_idx,
    input  logic signed [DATA_W-1:0] i_start,
    input  logic signed [DATA_W-1:0] i_end,
    output logic                     o_inside
);

    logic signed [DATA_W-1:0] r_value;
    logic                     r_have_a;
    logic                     r_have_b;
    logic [AW-1:0]            r_a_idx;
    logic [AW-1:0]            r_b_idx;
    logic signed [DATA_W-1:0] r_a_val;
    logic signed [DATA_W-1:0] r_b_val;
    logic                     hit_a;
    logic                     hit_b;

    // greatest start not above the value, later entry wins a tie
    assign hit_a = (i_start <= r_value) && (!r_have_a || (i_start >= r_a_val));
    // least end not below the value, later entry wins a tie
    assign hit_b = (i_end >= r_value) && (!r_have_b || (i_end <= r_b_val));

    // found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_a <= 1'b0;
            r_have_b <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have_a <= 1'b0;
            r_have_b <= 1'b0;
        end else if (i_ctl.step) begin
            if (hit_a) begin
                r_have_a <= 1'b1;
            end
            if (hit_b) begin
                r_have_b <= 1'b1;
            end
        end
    end

    // best entries and query value
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_value <= i_value;
        end else if (i_ctl.step) begin
            if (hit_a) begin
                r_a_idx <= i_idx;
                r_a_val <= i_start;
            end
            if (hit_b) begin
                r_b_idx <= i_idx;
                r_b_val <= i_end;
            end
        end
    end

    assign o_inside = r_have_a && r_have_b && (r_a_idx == r_b_idx);

endmodule

FILE: rtl/core/interval_table_point_query.sv
// top level of the interval table point query block
//
// Input channel: i_in_valid / o_in_stall carries one request: an insert
// (i_operation low) appends [i_range_start, i_range_end] to the table, a
// query (i_operation high) tests i_query_value against the stored ranges.
// Output channel: o_out_valid / i_out_stall returns exactly one result per
// request: o_status (high when an insert was dropped on a full table) and
// o_inside_res (query answer, low for inserts).
// Sequence: an insert, or a query on an empty table, goes from acceptance to
// ST_FINISH and from there into the output register. A query with N stored
// entries reads the table memory once per entry through its single read port
// in ST_SCAN and feeds the shared compare unit, then passes ST_DRAIN and
// ST_FINISH before its result is loaded into the output register.
// One request is worked on at a time; o_in_stall is high while it is.
// Reset empties the table at once (entry count to zero, no clearing pass);
// entries are only read below the count.
// A stalled result stays in the output register; the next request is taken
// meanwhile and its result waits in the final state until the register frees.
`include "assert_macros.svh"

module interval_table_point_query
    import itp_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_operation,
    input  logic signed [DATA_W-1:0] i_range_start,
    input  logic signed [DATA_W-1:0] i_range_end,
    input  logic signed [DATA_W-1:0] i_query_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_status,
    output logic                     o_inside_res
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            n_idx;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_rd_vld;
    logic                     r_res_status;
    logic                     r_use_scan;
    logic                     r_out_valid;
    logic                     r_out_status;
    logic                     r_out_inside;
    logic                     accept;
    logic                     full;
    logic                     wr_en;
    logic                     rd_en;
    logic                     load_out;
    logic                     scan_inside;
    logic signed [DATA_W-1:0] rd_start;
    logic signed [DATA_W-1:0] rd_end;
    t_scan_ctl                scan_ctl;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(MAX_RANGES));
    assign wr_en      = accept && (i_operation == OP_INSERT) && !full;

    // sequencer next state and controls
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if ((i_operation == OP_QUERY) && (r_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                n_idx = r_idx + AW'(1);
                if (CW'(r_idx) == (r_count - CW'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer state, entry count and read pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // scan index and per request result bits
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (rd_en) begin
            r_rd_idx <= r_idx;
        end
        if (accept) begin
            r_res_status <= ((i_operation == OP_INSERT) && full) ? STATUS_FULL : STATUS_OK;
            r_use_scan   <= (i_operation == OP_QUERY) && (r_count != '0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_inside <= r_use_scan && scan_inside;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_inside_res = r_out_inside;

    // range storage
    itp_table #(
        .DEPTH (MAX_RANGES),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[AW-1:0]),
        .i_wr_start (i_range_start),
        .i_wr_end   (i_range_end),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_idx),
        .o_rd_start (rd_start),
        .o_rd_end   (rd_end)
    );

    // compare unit control
    assign scan_ctl.clear = accept && (i_operation == OP_QUERY);
    assign scan_ctl.step  = r_rd_vld;

    itp_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_value  (i_query_value),
        .i_idx    (r_rd_idx),
        .i_start  (rd_start),
        .i_end    (rd_end),
        .o_inside (scan_inside)
    );

    // checks
    `ITP_ASSERT(a_count_bound, (r_count <= CW'(MAX_RANGES)), "entry count above table depth")
    `ITP_ASSERT(a_full_drop, ((accept && (i_operation == OP_INSERT) && full) |=> $stable(r_count)), "count moved on dropped insert")
    `ITP_ASSERT(a_scan_index, ((r_state == ST_SCAN) |-> (CW'(r_idx) < r_count)), "scan index past stored entries")
    `ITP_ASSERT_NEVER(a_rd_outside_scan, (r_rd_vld && (r_state != ST_SCAN) && (r_state != ST_DRAIN)), "read data outside scan")

endmodule

FILE: verif/tb_interval_table_point_query.sv
`timescale 1ns / 100ps
// self-checking testbench for the interval table point query block
module tb_interval_table_point_query;
    import itp_pkg::*;

    localparam int          TABLE_DEPTH  = MAX_RANGES_DEF;
    localparam int          RANDOM_ITEMS = 1500;
    localparam int          QUIET_TAIL   = 200;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // one request as presented on the input channel
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] first_val;
        logic signed [DATA_W-1:0] last_val;
        logic signed [DATA_W-1:0] probe_val;
        logic                     hold_for_drain;
    } t_request;

    // one result as returned on the output channel
    typedef struct packed {
        logic status;
        logic in_range;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic     in_valid  = 1'b0;
    logic     out_stall = 1'b0;
    t_request cur_req   = '0;
    logic     quiet     = 1'b0;

    logic o_in_stall;
    logic o_out_valid;
    logic o_status;
    logic o_inside_res;

    // requests waiting to be sent and results waiting to arrive
    t_request pending[$];
    t_result  expected_results[$];

    // ranges the stimulus plans to store, used to aim queries
    logic signed [DATA_W-1:0] planned_first[$];
    logic signed [DATA_W-1:0] planned_last[$];

    // shadow copy of the range table
    logic signed [DATA_W-1:0] tbl_first[TABLE_DEPTH];
    logic signed [DATA_W-1:0] tbl_last[TABLE_DEPTH];
    int                       tbl_count = 0;

    int unsigned accepted_cnt = 0;
    int unsigned done_cnt     = 0;
    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;

    interval_table_point_query u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (cur_req.op),
        .i_range_start (cur_req.first_val),
        .i_range_end   (cur_req.last_val),
        .i_query_value (cur_req.probe_val),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_status      (o_status),
        .o_inside_res  (o_inside_res)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // point lookup: latest entry with greatest start not above the value must
    // also be the latest entry with least end not below it
    function automatic logic point_inside(logic signed [DATA_W-1:0] v);
        int   a;
        int   b;
        logic has_a;
        logic has_b;
        a     = 0;
        b     = 0;
        has_a = 1'b0;
        has_b = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_first[i] <= v && (!has_a || tbl_first[i] >= tbl_first[a])) begin
                a     = i;
                has_a = 1'b1;
            end
            if (tbl_last[i] >= v && (!has_b || tbl_last[i] <= tbl_last[b])) begin
                b     = i;
                has_b = 1'b1;
            end
        end
        return has_a && has_b && (a == b);
    endfunction

    // apply one accepted request to the shadow table and return its result
    function automatic t_result apply_request(t_request req);
        t_result res;
        res.status   = STATUS_OK;
        res.in_range = 1'b0;
        if (req.op == OP_INSERT) begin
            if (tbl_count >= TABLE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                tbl_first[tbl_count] = req.first_val;
                tbl_last[tbl_count]  = req.last_val;
                tbl_count++;
            end
        end else begin
            res.in_range = point_inside(req.probe_val);
        end
        return res;
    endfunction

    // stimulus helpers, unused fields get random content
    task automatic add_insert(logic signed [DATA_W-1:0] first_v,
                              logic signed [DATA_W-1:0] last_v);
        t_request req;
        req.op             = OP_INSERT;
        req.first_val      = first_v;
        req.last_val       = last_v;
        req.probe_val      = $urandom;
        req.hold_for_drain = 1'b0;
        pending.push_back(req);
        if (planned_first.size() < TABLE_DEPTH) begin
            planned_first.push_back(first_v);
            planned_last.push_back(last_v);
        end
    endtask

    task automatic add_query(logic signed [DATA_W-1:0] v);
        t_request req;
        req.op             = OP_QUERY;
        req.first_val      = $urandom;
        req.last_val       = $urandom;
        req.probe_val      = v;
        req.hold_for_drain = 1'b0;
        pending.push_back(req);
    endtask

    // request driver
    always @(posedge i_clk) begin : driver
        t_request   nxt;
        logic       took;
        int         gap_left;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            took = in_valid && !o_in_stall;
            if (took) begin
                expected_results.push_back(apply_request(cur_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (in_valid && !took) begin
                // stalled: hold the request as it is
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending.size() == 0) begin
                in_valid <= 1'b0;
            end else if (pending[0].hold_for_drain && (took || done_cnt != accepted_cnt)) begin
                // let every outstanding result come back first
                in_valid <= 1'b0;
            end else begin
                nxt = pending.pop_front();
                cur_req  <= nxt;
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            quiet <= (pending.size() < QUIET_TAIL);
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : monitor
        t_result want;
        int      stall_left;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                done_cnt <= done_cnt + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0b inside %0b",
                             $time, o_status, o_inside_res);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0b actual %0b",
                                 $time, want.status, o_status);
                        err_cnt++;
                    end
                    if (o_inside_res !== want.in_range) begin
                        $display("%0t: inside mismatch, expected %0b actual %0b",
                                 $time, want.in_range, o_inside_res);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_interval_table_point_query: done, errors");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] probe;
        longint unsigned          span;
        longint unsigned          off;
        int                       k;
        int                       want_insert;

        // empty table
        add_query(32'sd0);
        add_query(VAL_MIN);
        // extreme single-value ranges
        add_insert(VAL_MIN, VAL_MIN);
        add_query(VAL_MIN);
        add_query(VAL_MAX);
        add_insert(VAL_MAX, VAL_MAX);
        add_query(VAL_MAX);
        pending[pending.size()-1].hold_for_drain = 1'b1;
        // ordinary range and its edges
        add_insert(-32'sd5, 32'sd5);
        add_query(32'sd0);
        add_query(-32'sd6);
        add_query(32'sd5);
        // reversed range never matches
        add_insert(32'sd100, 32'sd50);
        add_query(32'sd75);
        add_query(32'sd50);
        add_query(32'sd100);
        // start tie goes to the later entry
        add_insert(-32'sd5, 32'sd20);
        add_query(32'sd0);
        add_query(32'sd10);
        // exact duplicate overrides the earlier copy
        add_insert(-32'sd5, 32'sd20);
        add_query(32'sd10);
        add_query(32'sd20);
        add_query(-32'sd1);

        // random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            want_insert = (planned_first.size() < TABLE_DEPTH) ? ($urandom_range(0, 9) < 4)
                                                                : ($urandom_range(0, 99) < 8);
            if (want_insert) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        lo = int'($urandom_range(0, 400)) - 200;
                        hi = lo + int'($urandom_range(0, 60));
                    end
                    4: begin
                        k  = $urandom_range(0, planned_first.size() - 1);
                        lo = planned_first[k];
                        hi = lo + int'($urandom_range(0, 80));
                    end
                    5: begin
                        k  = $urandom_range(0, planned_last.size() - 1);
                        hi = planned_last[k];
                        lo = hi - int'($urandom_range(0, 80));
                    end
                    6: begin
                        hi = int'($urandom_range(0, 400)) - 200;
                        lo = hi + int'($urandom_range(1, 60));
                    end
                    7: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    8: begin
                        lo = $urandom_range(0, 1) ? VAL_MIN : $urandom;
                        hi = $urandom_range(0, 1) ? VAL_MAX : $urandom;
                    end
                    default: begin
                        lo = -int'($urandom_range(0, 32'h7FFF_FFFF));
                        hi = int'($urandom_range(0, 32'h7FFF_FFFF));
                    end
                endcase
                add_insert(lo, hi);
            end else begin
                k = (planned_first.size() == 0) ? 0
                                                : $urandom_range(0, planned_first.size() - 1);
                case ((planned_first.size() == 0) ? 9 : $urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // a point inside a planned range
                        lo = planned_first[k];
                        hi = planned_last[k];
                        if (lo > hi) begin
                            lo = planned_last[k];
                            hi = planned_first[k];
                        end
                        span  = longint'(hi) - longint'(lo) + 1;
                        off   = {$urandom, $urandom} % span;
                        probe = lo + off[DATA_W-1:0];
                    end
                    5, 6: begin
                        case ($urandom_range(0, 3))
                            0:       probe = planned_first[k];
                            1:       probe = planned_last[k];
                            2:       probe = planned_first[k] - 1;
                            default: probe = planned_last[k] + 1;
                        endcase
                    end
                    7: begin
                        case ($urandom_range(0, 3))
                            0:       probe = VAL_MIN;
                            1:       probe = VAL_MAX;
                            2:       probe = 32'sd0;
                            default: probe = -32'sd1;
                        endcase
                    end
                    8: probe = int'($urandom_range(0, 400)) - 200;
                    default: probe = $urandom;
                endcase
                add_query(probe);
            end
            if (n == RANDOM_ITEMS / 2)
                pending[pending.size()-1].hold_for_drain = 1'b1;
        end

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests to be taken and all results to return
        @(negedge i_clk);
        while (pending.size() != 0 || in_valid) @(negedge i_clk);
        while (done_cnt != accepted_cnt) @(negedge i_clk);
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results missing, expected status %0b inside %0b, actual none",
                     $time, expected_results.size(), expected_results[0].status,
                     expected_results[0].in_range);
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb_interval_table_point_query: done, clean");
        end else begin
            $display("tb_interval_table_point_query: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/itp_pkg.sv
rtl/core/itp_table.sv
rtl/core/itp_scan.sv
rtl/core/interval_table_point_query.sv
verif/tb_interval_table_point_query.sv
